@@ design/bdq_pkg.sv @@
`default_nettype none
package bdq_pkg;

    localparam int FUNC_W  = 3;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 5;

    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH     = 3'd4;

    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef logic        [FUNC_W-1:0]  t_func;
    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic        [STAT_W-1:0]  t_status;
    typedef logic        [OCC_W-1:0]   t_occ;

    // datapath -> controller
    typedef struct packed {
        logic in_valid;
        logic is_search;
        logic empty;
        logic out_free;
        logic last;
    } t_dp_status;

    // controller -> datapath
    typedef struct packed {
        logic in_ready;
        logic op_load;
        logic srch_start;
        logic srch_issue;
        logic srch_load;
    } t_dp_cmd;

endpackage
`default_nettype wire

@@ design/bdq_if.sv @@
`default_nettype none
interface bdq_in_if import bdq_pkg::*; ();
    logic   valid;
    logic   ready;
    t_func  func;
    t_value value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface bdq_out_if import bdq_pkg::*; ();
    logic    valid;
    logic    ready;
    t_status status;
    logic    found;
    t_value  found_value;
    t_occ    occupancy;

    modport source (output valid, output status, output found, output found_value,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input found, input found_value,
                    input occupancy, output ready);
endinterface
`default_nettype wire

@@ design/bdq_ctrl.sv @@
`default_nettype none
module bdq_ctrl import bdq_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SRCH = 2'd1;
    localparam logic [1:0] S_LAST = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_take;

    assign w_take = (r_state == S_IDLE) && i_status.out_free && i_status.in_valid;

    always_comb begin
        o_cmd.in_ready   = (r_state == S_IDLE) && i_status.out_free;
        o_cmd.op_load    = w_take && !(i_status.is_search && !i_status.empty);
        o_cmd.srch_start = w_take && i_status.is_search && !i_status.empty;
        o_cmd.srch_issue = (r_state == S_SRCH);
        o_cmd.srch_load  = (r_state == S_FIN) && i_status.out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.srch_start) n_state = S_SRCH;
            end
            S_SRCH: begin
                if (i_status.last) n_state = S_LAST;
            end
            S_LAST: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

@@ design/bdq_dp.sv @@
`default_nettype none
module bdq_dp import bdq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    bdq_in_if.sink       i_in,
    bdq_out_if.source    o_out,
    input  t_dp_cmd      i_cmd,
    output t_dp_status   o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [VALUE_W-1:0] r_mem [DEPTH];

    logic [AW-1:0]      r_head;
    logic [AW-1:0]      n_head;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [AW-1:0]      r_ptr;
    logic [CW-1:0]      r_left;
    t_value             r_key;
    logic [VALUE_W-1:0] r_rdata;
    logic               r_cmp_vld;
    logic               r_found;

    logic               r_out_valid;
    t_status            r_out_status;
    logic               r_out_found;
    t_value             r_out_fval;
    t_occ               r_out_occ;

    logic               w_full;
    logic               w_empty;
    logic [AW-1:0]      w_head_dec;
    logic [AW-1:0]      w_head_inc;
    logic [AW-1:0]      w_ptr_inc;
    logic [CW:0]        w_back_sum;
    logic [AW-1:0]      w_back_addr;
    logic               w_wr_en;
    logic [AW-1:0]      w_wr_addr;
    t_status            w_op_status;
    logic [31:0]        w_occ_new;
    logic [31:0]        w_occ_cur;

    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);

    assign w_head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;
    assign w_head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign w_ptr_inc  = (r_ptr == AW'(DEPTH - 1)) ? '0 : r_ptr + 1'b1;

    // back slot = head + count, wrapped once
    assign w_back_sum  = (CW+1)'(r_head) + (CW+1)'(r_count);
    assign w_back_addr = (w_back_sum >= (CW+1)'(DEPTH)) ?
                         AW'(w_back_sum - (CW+1)'(DEPTH)) : AW'(w_back_sum);

    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        w_wr_en     = 1'b0;
        w_wr_addr   = w_back_addr;
        w_op_status = STAT_DONE;
        case (i_in.func)
            FUNC_PUSH_FRONT: begin
                if (w_full) begin
                    w_op_status = STAT_FULL;
                end else begin
                    n_head    = w_head_dec;
                    n_count   = r_count + 1'b1;
                    w_wr_en   = 1'b1;
                    w_wr_addr = w_head_dec;
                end
            end
            FUNC_PUSH_BACK: begin
                if (w_full) begin
                    w_op_status = STAT_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                    w_wr_en = 1'b1;
                end
            end
            FUNC_POP_FRONT: begin
                if (w_empty) begin
                    w_op_status = STAT_EMPTY;
                end else begin
                    n_head  = w_head_inc;
                    n_count = r_count - 1'b1;
                end
            end
            FUNC_POP_BACK: begin
                if (w_empty) begin
                    w_op_status = STAT_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            FUNC_SEARCH: begin
                // only the empty case is resolved here
                w_op_status = STAT_EMPTY;
            end
            default: begin
                w_op_status = STAT_DONE;
            end
        endcase
    end

    assign w_occ_new = 32'(n_count);
    assign w_occ_cur = 32'(r_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.op_load && w_wr_en) r_mem[w_wr_addr] <= i_in.value;
        if (i_cmd.srch_issue)         r_rdata <= r_mem[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.srch_issue;
            if (i_cmd.op_load) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
            if (i_cmd.op_load || i_cmd.srch_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.srch_start) begin
            r_key   <= i_in.value;
            r_ptr   <= r_head;
            r_left  <= r_count;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.srch_issue) begin
                r_ptr  <= w_ptr_inc;
                r_left <= r_left - 1'b1;
            end
            if (r_cmp_vld && (r_rdata == r_key)) r_found <= 1'b1;
        end
        if (i_cmd.op_load) begin
            r_out_status <= w_op_status;
            r_out_found  <= 1'b0;
            r_out_fval   <= '0;
            r_out_occ    <= w_occ_new[OCC_W-1:0];
        end else if (i_cmd.srch_load) begin
            r_out_status <= STAT_DONE;
            r_out_found  <= r_found;
            r_out_fval   <= r_found ? r_key : '0;
            r_out_occ    <= w_occ_cur[OCC_W-1:0];
        end
    end

    always_comb begin
        o_status.in_valid  = i_in.valid;
        o_status.is_search = (i_in.func == FUNC_SEARCH);
        o_status.empty     = w_empty;
        o_status.out_free  = !r_out_valid || o_out.ready;
        o_status.last      = (r_left == CW'(1));
    end

    assign i_in.ready        = i_cmd.in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.found       = r_out_found;
    assign o_out.found_value = r_out_fval;
    assign o_out.occupancy   = r_out_occ;

endmodule
`default_nettype wire

@@ design/bounded_deque_with_search_unit.sv @@
// Insert and remove words land in the output register in the cycle after acceptance;
//   a search word reads the stored entries one per cycle, then a final compare, then the load.
// Inserts and removals are taken one word per cycle while the output register is free; a
//   search holds off the next word until its result is loaded, set by the single read port.
// Reset (synchronous, active low) clears head, count, sequencer and output valid;
//   entry memory is not cleared and only written slots are ever read.
`default_nettype none
module bounded_deque_with_search_unit import bdq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    bdq_in_if.sink    i_in,
    bdq_out_if.source o_out
);

    // Command and status between the sequencer and the list datapath.
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequencer: accepts a word when the output register is free, sends
    // non-search ops straight through, and steps a search over the stored entries.
    bdq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // Datapath: ring memory, head/count, search walk pointer, output register.
    bdq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_out    (o_out),
        .i_cmd    (w_cmd),
        .o_status (w_status)
    );

endmodule
`default_nettype wire

@@ test/testbench.sv @@
`default_nettype none
module testbench;
    import bdq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH          = 16;
    localparam int HEAD_W         = $clog2(DEPTH);
    localparam int FUNC_CODES     = 1 << FUNC_W;
    localparam int RANDOM_WORDS   = 450;
    localparam int MAX_GAP        = 19;
    localparam int KEY_POOL_MAX   = 24;
    // Long enough for a full search to finish, with a margin on top.
    localparam int DRAIN_CYCLES   = DEPTH + 8;
    // Longest quiet stretch of a correct run is roughly a sender gap, a full
    // search and a receiver stall back to back; allow many times that.
    localparam int WATCHDOG_LIMIT = 2000;

    localparam t_value VALUE_MIN = 32'sh8000_0000;
    localparam t_value VALUE_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        t_func  func;
        t_value value;
    } t_deque_cmd;

    typedef struct packed {
        t_status status;
        logic    found;
        t_value  found_value;
        t_occ    occupancy;
    } t_deque_result;

    logic i_clk;
    logic i_rst_n;

    bdq_in_if  in_bus ();
    bdq_out_if out_bus ();

    bounded_deque_with_search_unit #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus.sink),
        .o_out   (out_bus.source)
    );

    // Clock: 10 ns period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Command words waiting to be driven, and results owed by the block.
    t_deque_cmd    cmd_queue[$];
    t_deque_result owed_results[$];

    // Shadow copy of the deque, advanced once per accepted command word.
    t_value           shadow_mem[DEPTH];
    logic [HEAD_W-1:0] shadow_head;
    t_occ             shadow_count;

    // Generator-side bookkeeping: occupancy as the stimulus sees it and a
    // pool of recently inserted values to aim searches at.
    int     gen_count;
    t_value key_pool[$];
    int     random_words;
    int     total_words;

    int   errors;
    int   in_accepts;
    int   out_accepts;
    logic in_fire;
    logic out_fire;
    logic draining;

    // Driver state.
    bit         holding;
    t_deque_cmd cur_cmd;
    int         in_gap;
    int         out_gap;
    bit         in_calm;
    bit         out_calm;

    // Apply one command word to the shadow deque and return the result it owes.
    function automatic t_deque_result predict_deque(input t_func func, input t_value key);
        t_deque_result     res;
        logic [HEAD_W-1:0] slot;
        res = '0;
        res.status = STAT_DONE;
        case (func)
            FUNC_PUSH_FRONT: begin
                if (shadow_count >= DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    shadow_head = shadow_head - 1'b1;
                    shadow_mem[shadow_head] = key;
                    shadow_count = shadow_count + 1'b1;
                end
            end
            FUNC_PUSH_BACK: begin
                if (shadow_count >= DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    slot = shadow_head + shadow_count[HEAD_W-1:0];
                    shadow_mem[slot] = key;
                    shadow_count = shadow_count + 1'b1;
                end
            end
            FUNC_POP_FRONT: begin
                if (shadow_count == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    shadow_head = shadow_head + 1'b1;
                    shadow_count = shadow_count - 1'b1;
                end
            end
            FUNC_POP_BACK: begin
                if (shadow_count == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    shadow_count = shadow_count - 1'b1;
                end
            end
            FUNC_SEARCH: begin
                if (shadow_count == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    // Walk only stored entries, front to back.
                    for (int i = 0; i < shadow_count; i++) begin
                        slot = shadow_head + i[HEAD_W-1:0];
                        if (shadow_mem[slot] == key) begin
                            res.found       = 1'b1;
                            res.found_value = key;
                        end
                    end
                end
            end
            default: ;
        endcase
        res.occupancy = shadow_count;
        return res;
    endfunction

    // Queue one command word and track occupancy for shaping the stimulus.
    task automatic add_cmd(input t_func func, input t_value value);
        cmd_queue.push_back('{func: func, value: value});
        case (func)
            FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
                if (gen_count < DEPTH) begin
                    gen_count++;
                    key_pool.push_back(value);
                    if (key_pool.size() > KEY_POOL_MAX) begin
                        void'(key_pool.pop_front());
                    end
                end
            end
            FUNC_POP_FRONT, FUNC_POP_BACK: begin
                if (gen_count > 0) begin
                    gen_count--;
                end
            end
            default: ;
        endcase
    endtask

    // Mix of full-range, extreme and small values so that collisions happen.
    function automatic t_value pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4: begin
                case ($urandom_range(0, 3))
                    0: return VALUE_MIN;
                    1: return VALUE_MAX;
                    2: return '0;
                    default: return '1;
                endcase
            end
            5, 6: return $urandom_range(0, 7);
            default: begin
                if (key_pool.size() > 0) begin
                    return key_pool[$urandom_range(0, key_pool.size() - 1)];
                end
                return $urandom;
            end
        endcase
    endfunction

    // Search keys lean toward values that were inserted at some point.
    function automatic t_value pick_key();
        if (key_pool.size() > 0 && $urandom_range(0, 9) < 6) begin
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        end
        return pick_value();
    endfunction

    function automatic t_func pick_push();
        return $urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
    endfunction

    function automatic t_func pick_pop();
        return $urandom_range(0, 1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
    endfunction

    // Per-word wait; flip now and then into a stretch with no waits at all.
    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 29) == 0) begin
            calm = !calm;
        end
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic build_directed();
        // Removals and search on the empty deque.
        add_cmd(FUNC_POP_FRONT, 32'sd5);
        add_cmd(FUNC_POP_BACK, '1);
        add_cmd(FUNC_SEARCH, '0);
        // Unused function codes are no-ops.
        for (int k = FUNC_SEARCH + 1; k < FUNC_CODES; k++) begin
            add_cmd(t_func'(k), $urandom);
        end
        // Extremes at both ends.
        add_cmd(FUNC_PUSH_FRONT, '0);
        add_cmd(FUNC_PUSH_BACK, VALUE_MAX);
        add_cmd(FUNC_PUSH_FRONT, VALUE_MIN);
        add_cmd(FUNC_PUSH_BACK, '1);
        // Hit on key zero, hits on extremes, then a miss.
        add_cmd(FUNC_SEARCH, '0);
        add_cmd(FUNC_SEARCH, VALUE_MAX);
        add_cmd(FUNC_SEARCH, VALUE_MIN);
        add_cmd(FUNC_SEARCH, 32'sh1234_5678);
        // Drop both ends, then look for both removed values.
        add_cmd(FUNC_POP_FRONT, '0);
        add_cmd(FUNC_POP_BACK, '0);
        add_cmd(FUNC_SEARCH, VALUE_MIN);
        add_cmd(FUNC_SEARCH, '1);
    endtask

    task automatic build_random();
        int n;
        while (random_words < RANDOM_WORDS) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    // Fill to the top, searching along the way, then overrun.
                    while (gen_count < DEPTH) begin
                        if ($urandom_range(0, 3) == 0) begin
                            add_cmd(FUNC_SEARCH, pick_key());
                        end else begin
                            add_cmd(pick_push(), pick_value());
                        end
                        random_words++;
                    end
                    n = $urandom_range(1, 3);
                    repeat (n) begin
                        add_cmd(pick_push(), pick_value());
                        random_words++;
                    end
                    add_cmd(FUNC_SEARCH, pick_key());
                    random_words++;
                end
                3, 4, 5: begin
                    // Drain to empty, then underrun.
                    while (gen_count > 0) begin
                        if ($urandom_range(0, 3) == 0) begin
                            add_cmd(FUNC_SEARCH, pick_key());
                        end else begin
                            add_cmd(pick_pop(), pick_value());
                        end
                        random_words++;
                    end
                    n = $urandom_range(1, 2);
                    repeat (n) begin
                        add_cmd($urandom_range(0, 2) == 0 ? FUNC_SEARCH : pick_pop(),
                                pick_key());
                        random_words++;
                    end
                end
                6, 7, 8: begin
                    // Free mix of the five operations.
                    n = $urandom_range(5, 20);
                    repeat (n) begin
                        case ($urandom_range(0, 4))
                            0, 1: add_cmd(pick_push(), pick_value());
                            2, 3: add_cmd(pick_pop(), pick_value());
                            default: add_cmd(FUNC_SEARCH, pick_key());
                        endcase
                        random_words++;
                    end
                end
                default: begin
                    // Noise: unused codes, which do not count as real work.
                    n = $urandom_range(1, 3);
                    repeat (n) begin
                        add_cmd(t_func'($urandom_range(FUNC_SEARCH + 1, FUNC_CODES - 1)),
                                $urandom);
                    end
                end
            endcase
        end
    endtask

    // Input monitor: on every accepted command word, advance the shadow deque
    // and record the result it owes.
    always @(posedge i_clk) begin : cmd_monitor
        in_fire <= i_rst_n && in_bus.valid && in_bus.ready;
        if (i_rst_n && in_bus.valid && in_bus.ready) begin
            owed_results.push_back(predict_deque(in_bus.func, in_bus.value));
            in_accepts <= in_accepts + 1;
        end
    end

    // Output monitor: compare each accepted result word with the oldest owed one.
    always @(posedge i_clk) begin : result_monitor
        t_deque_result got;
        t_deque_result want;
        out_fire <= i_rst_n && out_bus.valid && out_bus.ready;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            out_accepts <= out_accepts + 1;
            got.status      = out_bus.status;
            got.found       = out_bus.found;
            got.found_value = out_bus.found_value;
            got.occupancy   = out_bus.occupancy;
            if (owed_results.size() == 0) begin
                $display("%0t: result word with nothing owed: expected none, actual %0h",
                         $time, got);
                errors++;
            end else begin
                want = owed_results.pop_front();
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("found", 32'(want.found), 32'(got.found));
                check_field("found_value", want.found_value, got.found_value);
                check_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
            end
        end
    end

    // Command driver: hold a word until accepted, then wait its gap and
    // advance to the next. Valid gets exactly one assignment per edge.
    always @(negedge i_clk) begin : cmd_driver
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_fire) begin
                holding = 1'b0;
            end
            if (!holding) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (cmd_queue.size() > 0) begin
                    cur_cmd = cmd_queue.pop_front();
                    holding = 1'b1;
                    in_gap  = draw_gap(in_calm);
                end
            end
            in_bus.valid <= holding;
            if (holding) begin
                in_bus.func  <= cur_cmd.func;
                in_bus.value <= cur_cmd.value;
            end
        end
    end

    // Result receiver: after each accepted word, stall ready for a drawn gap.
    // Keep ready high once the run is draining so stray words show up.
    always @(negedge i_clk) begin : result_receiver
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_fire) begin
                out_gap = draw_gap(out_calm);
            end
            if (draining) begin
                out_bus.ready <= 1'b1;
            end else if (out_gap > 0) begin
                out_gap--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    initial begin : sequencer
        int  idle_cycles;
        int  last_progress;
        bit  timed_out;

        // Drive every input to a known value before the first edge.
        i_rst_n       = 1'b0;
        in_bus.valid  = 1'b0;
        in_bus.func   = FUNC_PUSH_FRONT;
        in_bus.value  = '0;
        out_bus.ready = 1'b0;
        in_fire       = 1'b0;
        out_fire      = 1'b0;
        draining      = 1'b0;
        holding       = 1'b0;
        in_gap        = 0;
        out_gap       = 0;
        in_calm       = 1'b0;
        out_calm      = 1'b0;
        errors        = 0;
        in_accepts    = 0;
        out_accepts   = 0;
        gen_count     = 0;
        random_words  = 0;
        shadow_head   = '0;
        shadow_count  = '0;
        for (int i = 0; i < DEPTH; i++) begin
            shadow_mem[i] = '0;
        end

        build_directed();
        build_random();
        total_words = cmd_queue.size();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Run until every word is accepted and every result has arrived;
        // bail out if nothing moves on either side for too long.
        idle_cycles   = 0;
        last_progress = 0;
        timed_out     = 1'b0;
        while ((in_accepts < total_words || owed_results.size() > 0) && !timed_out) begin
            @(negedge i_clk);
            if (in_accepts + out_accepts != last_progress) begin
                last_progress = in_accepts + out_accepts;
                idle_cycles   = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    timed_out = 1'b1;
                end
            end
        end

        if (timed_out) begin
            $display("%0t: watchdog expired: expected %0d results, actual %0d",
                     $time, in_accepts, out_accepts);
            errors++;
        end else begin
            // Hold ready high and watch for stray result words.
            draining <= 1'b1;
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            if (owed_results.size() != 0) begin
                $display("%0t: results left over: expected 0, actual %0d",
                         $time, owed_results.size());
                errors++;
            end
        end

        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ bounded_deque_with_search_unit.f @@
design/bdq_pkg.sv
design/bdq_if.sv
design/bdq_ctrl.sv
design/bdq_dp.sv
design/bounded_deque_with_search_unit.sv
test/testbench.sv
